// File: hw/rtl/rcpd_pkg.sv
// ----------------------------------------------------------------------------
// rcpd_pkg
// shared types, codes and reset values for the rc pulse width decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rcpd_pkg;

    // default sizing handed to the top level parameters
    localparam int CHANNELS_DEF  = 6;
    localparam int TIME_BITS_DEF = 32;

    // fixed field widths
    localparam int CH_W        = 3;
    localparam int TS_W        = 32;
    localparam int VALUE_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // item function codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS    = 3'd4;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] NEUTRAL_RST = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] MAX_RST     = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] MIN_RST     = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] TOL_RST     = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LOSS_RST    = 16'd0;

    typedef enum logic [1:0] {
        DIR_LOSS = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd2,
        DIR_MID  = 2'd3
    } t_dir;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] neutral_width;
        logic [CFG_DATA_W-1:0] max_width;
        logic [CFG_DATA_W-1:0] min_width;
        logic [CFG_DATA_W-1:0] tolerance;
        logic [CFG_DATA_W-1:0] loss_value;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/rcpd_if.sv
// ----------------------------------------------------------------------------
// rcpd interfaces
// valid/ready channels for items, results and configuration writes
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpd_item_if import rcpd_pkg::*;;
    logic            valid;
    logic            ready;
    logic            func;
    logic [CH_W-1:0] channel;
    logic            level;
    logic [TS_W-1:0] time_us;

    modport source (output valid, output func, output channel, output level,
                    output time_us, input ready);
    modport sink   (input valid, input func, input channel, input level,
                    input time_us, output ready);
endinterface

interface rcpd_result_if import rcpd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    t_dir               direction;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output out_channel, output direction,
                    output value, input ready);
    modport sink   (input valid, input out_channel, input direction,
                    input value, output ready);
endinterface

interface rcpd_cfg_if import rcpd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rcpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcpd_cfg_regs
// reference widths, tolerance and loss value, written by index
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_cfg_regs import rcpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.neutral_width <= NEUTRAL_RST;
            r_cfg.max_width     <= MAX_RST;
            r_cfg.min_width     <= MIN_RST;
            r_cfg.tolerance     <= TOL_RST;
            r_cfg.loss_value    <= LOSS_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_NEUTRAL: r_cfg.neutral_width <= i_wr_data;
                REG_MAX:     r_cfg.max_width     <= i_wr_data;
                REG_MIN:     r_cfg.min_width     <= i_wr_data;
                REG_TOL:     r_cfg.tolerance     <= i_wr_data;
                REG_LOSS:    r_cfg.loss_value    <= i_wr_data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/rcpd_chan_state.sv
// ----------------------------------------------------------------------------
// rcpd_chan_state
// per-channel pulse start, current width and previous width
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_chan_state import rcpd_pkg::*; #(
    parameter  int CHANNELS  = CHANNELS_DEF,
    parameter  int TIME_BITS = TIME_BITS_DEF,
    localparam int IdxW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_edge_en,
    input  logic                 i_read_en,
    input  logic [IdxW-1:0]      i_idx,
    input  logic                 i_level,
    input  logic [TIME_BITS-1:0] i_time,
    output logic [TIME_BITS-1:0] o_cur,
    output logic [TIME_BITS-1:0] o_prev
);

    logic [TIME_BITS-1:0] r_start [CHANNELS];
    logic [TIME_BITS-1:0] r_width [CHANNELS];
    logic [TIME_BITS-1:0] r_prev  [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_start[i] <= '0;
                r_width[i] <= '0;
                r_prev[i]  <= '0;
            end
        end else begin
            if (i_edge_en) begin
                if (i_level) begin
                    r_start[i_idx] <= i_time;
                end else begin
                    // wraps modulo the timestamp width
                    r_width[i_idx] <= i_time - r_start[i_idx];
                end
            end
            if (i_read_en) begin
                r_prev[i_idx] <= r_width[i_idx];
            end
        end
    end

    assign o_cur  = r_width[i_idx];
    assign o_prev = r_prev[i_idx];

endmodule

`default_nettype wire

// File: hw/rtl/rcpd_classify.sv
// ----------------------------------------------------------------------------
// rcpd_classify
// snaps a held pulse width to max, min or neutral, passes it through between them, or reports loss
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_classify import rcpd_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  t_cfg                 i_cfg,
    input  logic                 i_in_range,
    input  logic [TIME_BITS-1:0] i_cur,
    input  logic [TIME_BITS-1:0] i_prev,
    output t_dir                 o_dir,
    output logic [VALUE_W-1:0]   o_value
);

    // two guard bits: sign plus carry of ref + tolerance
    localparam int CW = TIME_BITS + 2;
    localparam int PW = CW - CFG_DATA_W;

    logic [TIME_BITS-1:0] w;
    logic signed [CW-1:0] w_s, tol_s, max_s, min_s, neu_s;
    logic signed [CW-1:0] max_hi, max_lo, min_hi, min_lo, neu_hi, neu_lo;
    logic                 both_zero, out_win, in_max, in_min, in_neu, above_neu;

    always_comb begin
        w      = (i_cur != '0) ? i_cur : i_prev;
        w_s    = signed'({2'b00, w});
        tol_s  = signed'({{PW{1'b0}}, i_cfg.tolerance});
        max_s  = signed'({{PW{1'b0}}, i_cfg.max_width});
        min_s  = signed'({{PW{1'b0}}, i_cfg.min_width});
        neu_s  = signed'({{PW{1'b0}}, i_cfg.neutral_width});

        max_hi = max_s + tol_s;
        max_lo = max_s - tol_s;
        min_hi = min_s + tol_s;
        min_lo = min_s - tol_s;
        neu_hi = neu_s + tol_s;
        neu_lo = neu_s - tol_s;

        both_zero = (i_cur == '0) && (i_prev == '0);
        out_win   = (w_s > max_hi) || (w_s < min_lo);
        in_max    = (w_s >= max_lo) && (w_s <= max_hi);
        in_min    = (w_s >= min_lo) && (w_s <= min_hi);
        in_neu    = (w_s >= neu_lo) && (w_s <= neu_hi);
        above_neu = (w_s > neu_s);

        if (!i_in_range || both_zero || out_win) begin
            o_dir   = DIR_LOSS;
            o_value = i_cfg.loss_value;
        end else if (in_max) begin
            o_dir   = DIR_INC;
            o_value = i_cfg.max_width;
        end else if (in_min) begin
            o_dir   = DIR_DEC;
            o_value = i_cfg.min_width;
        end else if (in_neu) begin
            o_dir   = DIR_MID;
            o_value = i_cfg.neutral_width;
        end else begin
            o_dir   = above_neu ? DIR_INC : DIR_DEC;
            o_value = w[VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rc_pwm_channel_decoder.sv
// ----------------------------------------------------------------------------
// rc_pwm_channel_decoder
// multi-channel rc receiver pulse width decoder with snap-to-reference
// ----------------------------------------------------------------------------
//
//  port       dir  word                                   moves when
//  i_item     in   func, channel, level, time_us          valid && ready
//  i_cfg      in   index, data                            valid && ready
//  o_result   out  out_channel, direction, value          valid && ready
//
//  one word per cycle unless a read stalls: a word waits in the input
//  register, where the channel state is read, updated and classified, then
//  a read lands in the result register and is held there until taken
//  edge words give no result and never wait on the result side
//  a read stalls only when the result register is full and not taken;
//  i_item.ready follows that condition, so a new word still enters while a
//  finished result waits, unless a read is held in the input register
//  synchronous active-low reset clears all channel state, the valid flags
//  and restores the register defaults; i_cfg is always ready
//
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pwm_channel_decoder import rcpd_pkg::*; #(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rcpd_item_if.sink      i_item,
    rcpd_cfg_if.sink       i_cfg,
    rcpd_result_if.source  o_result
);

    localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // input register
    logic                 r_in_vld, n_in_vld;
    logic                 r_in_func;
    logic [CH_W-1:0]      r_in_ch;
    logic                 r_in_level;
    logic [TIME_BITS-1:0] r_in_time;

    // result register
    logic                 r_out_vld, n_out_vld;
    logic [CH_W-1:0]      r_out_ch;
    t_dir                 r_out_dir;
    logic [VALUE_W-1:0]   r_out_value;

    logic                 out_free, advance, load_out;
    logic                 edge_en, read_en, in_range;
    logic [IdxW+CH_W-1:0] ch_ext;
    logic [IdxW-1:0]      idx;
    logic [TIME_BITS+TS_W-1:0] time_ext;
    logic [TIME_BITS-1:0] cur_w, prev_w;
    t_dir                 cls_dir;
    logic [VALUE_W-1:0]   cls_value;
    t_cfg                 cfg;

    // ---------------- handshake ----------------
    // edge words retire without touching the result side
    assign out_free = !r_out_vld || o_result.ready;
    assign advance  = r_in_vld && ((r_in_func == FUNC_EDGE) || out_free);
    assign load_out = advance && (r_in_func == FUNC_READ);

    assign i_item.ready = !r_in_vld || advance;
    assign i_cfg.ready  = 1'b1;

    always_comb begin
        n_in_vld = r_in_vld;
        if (i_item.ready) begin
            n_in_vld = i_item.valid;
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (load_out) begin
            n_out_vld = 1'b1;
        end else if (o_result.ready) begin
            n_out_vld = 1'b0;
        end
    end

    // low TIME_BITS bits of the timestamp, zero-extended if wider
    assign time_ext = {{TIME_BITS{1'b0}}, i_item.time_us};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_func  <= i_item.func;
            r_in_ch    <= i_item.channel;
            r_in_level <= i_item.level;
            r_in_time  <= time_ext[TIME_BITS-1:0];
        end
    end

    // ---------------- channel decode ----------------
    assign ch_ext   = {{IdxW{1'b0}}, r_in_ch};
    assign idx      = ch_ext[IdxW-1:0];
    assign in_range = (ch_ext < (IdxW+CH_W)'(CHANNELS));

    // out-of-range channels leave the state alone
    assign edge_en = advance && (r_in_func == FUNC_EDGE) && in_range;
    assign read_en = load_out && in_range;

    rcpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid && i_cfg.ready),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    rcpd_chan_state #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_edge_en (edge_en),
        .i_read_en (read_en),
        .i_idx     (idx),
        .i_level   (r_in_level),
        .i_time    (r_in_time),
        .o_cur     (cur_w),
        .o_prev    (prev_w)
    );

    rcpd_classify #(
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .i_cfg      (cfg),
        .i_in_range (in_range),
        .i_cur      (cur_w),
        .i_prev     (prev_w),
        .o_dir      (cls_dir),
        .o_value    (cls_value)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_ch    <= r_in_ch;
            r_out_dir   <= cls_dir;
            r_out_value <= cls_value;
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.out_channel = r_out_ch;
    assign o_result.direction   = r_out_dir;
    assign o_result.value       = r_out_value;

endmodule

`default_nettype wire

// File: hw/rtl/rcpd_checker.sv
// ----------------------------------------------------------------------------
// rcpd_checker
// port-level checks on the result channel of the pulse width decoder
// ----------------------------------------------------------------------------
`default_nettype none

module rcpd_checker import rcpd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire logic [CH_W-1:0]    i_res_channel,
    input wire t_dir               i_res_dir,
    input wire logic [VALUE_W-1:0] i_res_value
);

    // a stalled result holds its word
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_channel)
            && $stable(i_res_dir) && $stable(i_res_value))
        else $error("result word changed while stalled");

    // nothing pending out of reset
    a_res_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // unknown channels always report loss
    a_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_channel >= CH_W'(CHANNELS)) && (CHANNELS < 8)
            |-> i_res_dir == DIR_LOSS)
        else $error("out-of-range channel without loss");

endmodule

bind rc_pwm_channel_decoder rcpd_checker #(
    .CHANNELS (CHANNELS)
) u_rcpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_result.valid),
    .i_res_ready   (o_result.ready),
    .i_res_channel (o_result.out_channel),
    .i_res_dir     (o_result.direction),
    .i_res_value   (o_result.value)
);

`default_nettype wire
